[design/rcrc_pkg.sv]
// Shared types, constants and CRC functions for the reflected CRC core.
package rcrc_pkg;

    localparam int unsigned CFG_IDX_W = 2;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_POLYNOMIAL    = 2'd0,
        CFG_INITIAL_VALUE = 2'd1,
        CFG_CRC_LENGTH    = 2'd2,
        CFG_CHECK_MODE    = 2'd3
    } cfg_index_t;

    localparam logic [31:0] POLY_RESET     = 32'hEDB8_8320;
    localparam logic [31:0] INIT_RESET     = 32'hFFFF_FFFF;
    localparam logic [2:0]  LEN_RESET      = 3'd4;
    localparam logic [2:0]  LEN_MIN        = 3'd2;
    localparam logic [2:0]  LEN_MAX        = 3'd4;

    // Results queued for the output side by one item
    typedef struct packed {
        logic [31:0] data;   // bytes to send, lowest first
        logic [2:0]  count;  // number of result items
        logic        ok;     // check pass flag
    } burst_t;

    // One byte through the LSB-first CRC: xor in, then eight shift steps
    function automatic logic [31:0] crc_byte_update(input logic [31:0] crc,
                                                    input logic [7:0]  data,
                                                    input logic [31:0] poly);
        logic [31:0] c;
        c = crc ^ {24'd0, data};
        for (int i = 0; i < 8; i++) begin
            if (c[0]) begin
                c = (c >> 1) ^ poly;
            end else begin
                c = c >> 1;
            end
        end
        return c;
    endfunction

    // Clamp the length register into 2..4
    function automatic logic [2:0] crc_len(input logic [2:0] len);
        logic [2:0] l;
        if (len < LEN_MIN) begin
            l = LEN_MIN;
        end else if (len > LEN_MAX) begin
            l = LEN_MAX;
        end else begin
            l = len;
        end
        return l;
    endfunction

endpackage

[design/rcrc_engine.sv]
// Input register, configuration registers and CRC/trailer state update.
module rcrc_engine (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [7:0]                    s_tdata,
    input  logic                          s_tlast,
    input  logic                          cfg_valid,
    input  logic [rcrc_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [31:0]                   cfg_data,
    input  logic                          emit_free,
    output logic                          burst_load,
    output rcrc_pkg::burst_t              burst
);

    logic        in_valid_reg;
    logic [7:0]  in_byte_reg;
    logic        in_end_reg;

    logic [31:0] poly_reg;
    logic [31:0] init_reg;
    logic [2:0]  crc_length_reg;
    logic        check_mode_reg;

    logic [31:0] crc_reg;
    logic [31:0] crc_next;
    logic        in_trailer_reg;
    logic [2:0]  trailer_count_reg;
    logic        mismatch_reg;

    logic [2:0]  len;
    logic [31:0] crc_upd;
    logic [31:0] inv_crc;
    logic [7:0]  inv_sel;
    logic [2:0]  trail_cnt_inc;
    logic        trail_done;
    logic        byte_mismatch;
    logic        produces;
    logic        fire;

    always_comb begin
        len           = rcrc_pkg::crc_len(crc_length_reg);
        inv_crc       = ~crc_reg;
        inv_sel       = 8'(inv_crc >> {trailer_count_reg[1:0], 3'b000});
        trail_cnt_inc = trailer_count_reg + 3'd1;
        trail_done    = (trail_cnt_inc >= len);
        byte_mismatch = (in_byte_reg != inv_sel);
        crc_upd       = rcrc_pkg::crc_byte_update(crc_reg, in_byte_reg, poly_reg);
        produces      = in_trailer_reg ? trail_done : (in_end_reg && !check_mode_reg);
        // hold the item while the result register cannot take its results
        fire          = in_valid_reg && (!produces || emit_free);
        burst_load    = fire && produces;
        if (in_trailer_reg) begin
            burst.data  = 32'd0;
            burst.count = 3'd1;
            burst.ok    = !(mismatch_reg || byte_mismatch);
        end else begin
            burst.data  = ~crc_upd;
            burst.count = len;
            burst.ok    = 1'b0;
        end

        crc_next = crc_reg;
        if (fire) begin
            if (in_trailer_reg) begin
                if (trail_done) begin
                    crc_next = init_reg;
                end
            end else if (in_end_reg && !check_mode_reg) begin
                crc_next = init_reg;
            end else begin
                crc_next = crc_upd;
            end
        end
        // a start value write reloads the CRC at once
        if (cfg_valid && (rcrc_pkg::cfg_index_t'(cfg_index) == rcrc_pkg::CFG_INITIAL_VALUE))
        begin
            crc_next = cfg_data;
        end
    end

    assign s_tready = !in_valid_reg || fire;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg      <= 1'b0;
            poly_reg          <= rcrc_pkg::POLY_RESET;
            init_reg          <= rcrc_pkg::INIT_RESET;
            crc_length_reg    <= rcrc_pkg::LEN_RESET;
            check_mode_reg    <= 1'b0;
            crc_reg           <= rcrc_pkg::INIT_RESET;
            in_trailer_reg    <= 1'b0;
            trailer_count_reg <= 3'd0;
            mismatch_reg      <= 1'b0;
        end else begin
            if (s_tvalid && s_tready) begin
                in_valid_reg <= 1'b1;
                in_byte_reg  <= s_tdata;
                in_end_reg   <= s_tlast;
            end else if (fire) begin
                in_valid_reg <= 1'b0;
            end

            crc_reg <= crc_next;

            if (fire) begin
                if (in_trailer_reg) begin
                    if (trail_done) begin
                        in_trailer_reg    <= 1'b0;
                        trailer_count_reg <= 3'd0;
                        mismatch_reg      <= 1'b0;
                    end else begin
                        trailer_count_reg <= trail_cnt_inc;
                        mismatch_reg      <= mismatch_reg || byte_mismatch;
                    end
                end else if (in_end_reg && check_mode_reg) begin
                    in_trailer_reg    <= 1'b1;
                    trailer_count_reg <= 3'd0;
                    mismatch_reg      <= 1'b0;
                end
            end

            if (cfg_valid) begin
                unique case (rcrc_pkg::cfg_index_t'(cfg_index))
                    rcrc_pkg::CFG_POLYNOMIAL: begin
                        poly_reg <= cfg_data;
                    end
                    rcrc_pkg::CFG_INITIAL_VALUE: begin
                        init_reg <= cfg_data;
                    end
                    rcrc_pkg::CFG_CRC_LENGTH: begin
                        crc_length_reg <= cfg_data[2:0];
                    end
                    rcrc_pkg::CFG_CHECK_MODE: begin
                        check_mode_reg <= cfg_data[0];
                    end
                    default: begin
                    end
                endcase
            end
        end
    end

endmodule

[design/rcrc_emit.sv]
// Result register: sends the queued CRC bytes or the check flag one item a cycle while m_tready is high.
module rcrc_emit (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             burst_load,
    input  rcrc_pkg::burst_t burst,
    output logic             emit_free,
    output logic             m_tvalid,
    input  logic             m_tready,
    output logic [7:0]       m_tdata,
    output logic             m_tuser,
    output logic             m_tlast
);

    logic [31:0] data_reg;
    logic [2:0]  count_reg;
    logic        ok_reg;

    assign m_tvalid  = (count_reg != 3'd0);
    assign m_tdata   = data_reg[7:0];
    assign m_tuser   = ok_reg;
    assign m_tlast   = (count_reg == 3'd1);
    assign emit_free = (count_reg == 3'd0) || ((count_reg == 3'd1) && m_tready);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= 3'd0;
        end else if (burst_load) begin
            count_reg <= burst.count;
            data_reg  <= burst.data;
            ok_reg    <= burst.ok;
        end else if (m_tvalid && m_tready) begin
            // advance to the next byte
            count_reg <= count_reg - 3'd1;
            data_reg  <= data_reg >> 8;
        end
    end

endmodule

[design/reflected_crc_generate_check_core.sv]
// An accepted item is held in the input register; its results load the result register
//   once that register is free, and the first result is offered from there.
// Throughput: one input item per cycle; a generating end byte queues 2 to 4 CRC bytes
//   in the result register and a check result a single flag, and the next
//   result-producing item waits in the input register until the register drains.
// Reset (aresetn low, synchronous) restores register defaults, loads the CRC
//   with the initial value and empties the input and result registers.
module reflected_crc_generate_check_core (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [7:0]                    s_tdata,   // [7:0] data_byte
    input  logic                          s_tlast,   // payload_end
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [7:0]                    m_tdata,   // [7:0] crc_byte
    output logic                          m_tuser,   // [0] crc_ok
    output logic                          m_tlast,   // last_result
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [rcrc_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [31:0]                   cfg_data
);

    logic             emit_free;
    logic             burst_load;
    rcrc_pkg::burst_t burst;

    assign cfg_ready = 1'b1;

    rcrc_engine u_engine (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tlast    (s_tlast),
        .cfg_valid  (cfg_valid),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .emit_free  (emit_free),
        .burst_load (burst_load),
        .burst      (burst)
    );

    rcrc_emit u_emit (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .burst_load (burst_load),
        .burst      (burst),
        .emit_free  (emit_free),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tuser    (m_tuser),
        .m_tlast    (m_tlast)
    );

endmodule

[design/rcrc_checker.sv]
// Port-level checks for the reflected CRC core, bound to the top level.
module rcrc_checker (
    input logic       aclk,
    input logic       aresetn,
    input logic       s_tvalid,
    input logic       s_tready,
    input logic       m_tvalid,
    input logic       m_tready,
    input logic [7:0] m_tdata,
    input logic       m_tuser,
    input logic       m_tlast
);

    // a stalled result holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser)
            && $stable(m_tlast))
        else $error("result changed while stalled");

    // a passing check is a single zero-data item that ends the packet
    a_ok_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser |-> m_tlast && (m_tdata == 8'd0))
        else $error("crc_ok on a non-final or nonzero result");

    // reset empties the result register
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

    // the input only stalls while the result register is busy
    a_ready_free: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && (!m_tvalid || (m_tready && m_tlast)) |-> s_tready)
        else $error("input stalled with a free result register");

endmodule

bind reflected_crc_generate_check_core rcrc_checker u_rcrc_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
);

[test/reflected_crc_generate_check_core_test.sv]
// Self-checking testbench for the reflected CRC generate/check core.
`timescale 1ns / 1ps

module reflected_crc_generate_check_core_test;

    localparam int unsigned IDLE_LIMIT = 1000;
    localparam int unsigned ITEM_TARGET = 350;
    localparam int unsigned CALM_FROM = 300;

    typedef enum {ROW_ITEM, ROW_WRITE} row_kind_t;

    typedef struct {
        row_kind_t            kind;
        rcrc_pkg::cfg_index_t reg_idx;
        logic [31:0]          value;      // register data, or the data byte in [7:0]
        logic                 last;
        logic                 typed;      // expected result written into the row
        logic [31:0]          typed_word; // expected CRC bytes, lowest first
        logic                 typed_ok;
    } stim_row_t;

    typedef struct packed {
        logic [7:0] crc_byte;
        logic       ok;
        logic       last;
    } crc_result_t;

    logic                 aclk = 1'b0;
    logic                 aresetn = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [7:0]           s_tdata = '0;
    logic                 s_tlast = 1'b0;
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [7:0]           m_tdata;
    logic                 m_tuser;
    logic                 m_tlast;
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    rcrc_pkg::cfg_index_t cfg_index = rcrc_pkg::CFG_POLYNOMIAL;
    logic [31:0]          cfg_data = '0;

    reflected_crc_generate_check_core i_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // Predictor state: register copies and the running CRC
    logic [31:0] poly_r = rcrc_pkg::POLY_RESET;
    logic [31:0] init_r = rcrc_pkg::INIT_RESET;
    logic [2:0]  len_r = rcrc_pkg::LEN_RESET;
    logic        check_r = 1'b0;
    logic [31:0] crc_r = rcrc_pkg::INIT_RESET;
    logic        in_trl = 1'b0;
    logic [2:0]  trl_cnt = '0;
    logic        miss = 1'b0;

    crc_result_t crc_expect_q[$];
    stim_row_t   rows[$];
    crc_result_t head;

    int unsigned err_count = 0;
    int unsigned items_sent = 0;
    int unsigned results_seen = 0;
    int unsigned writes_done = 0;
    int unsigned idle_cycles = 0;
    int unsigned stall_left = 0;
    logic        calm = 1'b0;

    function automatic int unsigned eff_len(logic [2:0] l);
        if (l < 3'd2) return 2;
        if (l > 3'd4) return 4;
        return int'(l);
    endfunction

    function automatic logic [7:0] inv_byte(int unsigned k);
        return 8'((~crc_r) >> ((k % 4) * 8));
    endfunction

    function automatic logic [31:0] crc_step(logic [31:0] crc, logic [7:0] b);
        logic [31:0] c;
        c = crc ^ {24'd0, b};
        for (int i = 0; i < 8; i++) begin
            c = c[0] ? ((c >> 1) ^ poly_r) : (c >> 1);
        end
        return c;
    endfunction

    // Advance the predictor by one accepted item and queue its results
    task automatic track_item(logic [7:0] b, logic last, logic typed, logic [31:0] word,
                              logic ok);
        int unsigned len;
        crc_result_t r;
        len = eff_len(len_r);
        if (in_trl) begin
            if (b != inv_byte(trl_cnt)) miss = 1'b1;
            trl_cnt = trl_cnt + 3'd1;
            if (trl_cnt >= len) begin
                r.crc_byte = typed ? word[7:0] : 8'd0;
                r.ok = typed ? ok : !miss;
                r.last = 1'b1;
                crc_expect_q.push_back(r);
                in_trl = 1'b0;
                trl_cnt = '0;
                miss = 1'b0;
                crc_r = init_r;
            end
        end else begin
            crc_r = crc_step(crc_r, b);
            if (last && check_r) begin
                in_trl = 1'b1;
                trl_cnt = '0;
                miss = 1'b0;
            end else if (last) begin
                for (int k = 0; k < len; k++) begin
                    r.crc_byte = typed ? word[k*8 +: 8] : inv_byte(k);
                    r.ok = typed ? ok : 1'b0;
                    r.last = (k + 1 == len);
                    crc_expect_q.push_back(r);
                end
                crc_r = init_r;
            end
        end
    endtask

    task automatic track_write(rcrc_pkg::cfg_index_t idx, logic [31:0] val);
        case (idx)
            rcrc_pkg::CFG_POLYNOMIAL: poly_r = val;
            rcrc_pkg::CFG_INITIAL_VALUE: begin
                init_r = val;
                crc_r = val;
            end
            rcrc_pkg::CFG_CRC_LENGTH: len_r = val[2:0];
            rcrc_pkg::CFG_CHECK_MODE: check_r = val[0];
            default: ;
        endcase
    endtask

    task automatic send_item(logic [7:0] b, logic last, logic typed, logic [31:0] word,
                             logic ok);
        calm = (items_sent >= CALM_FROM);
        @(negedge aclk);
        if (!calm && $urandom_range(0, 4) == 0) begin
            s_tvalid = 1'b0;
            repeat ($urandom_range(1, 3)) @(negedge aclk);
        end
        s_tvalid = 1'b1;
        s_tdata = b;
        s_tlast = last;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        track_item(b, last, typed, word, ok);
        items_sent++;
    endtask

    // Drop valid, drain outstanding results, then let the pipeline settle
    task automatic wait_idle();
        @(negedge aclk);
        s_tvalid = 1'b0;
        while (crc_expect_q.size() != 0) @(negedge aclk);
        repeat (4) @(negedge aclk);
    endtask

    task automatic write_reg(rcrc_pkg::cfg_index_t idx, logic [31:0] val);
        cfg_valid = 1'b1;
        cfg_index = idx;
        cfg_data = val;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        track_write(idx, val);
        writes_done++;
        @(negedge aclk);
        cfg_valid = 1'b0;
    endtask

    task automatic add_row(row_kind_t kind, rcrc_pkg::cfg_index_t idx, logic [31:0] value,
                           logic last, logic typed, logic [31:0] word, logic ok);
        stim_row_t r;
        r.kind = kind;
        r.reg_idx = idx;
        r.value = value;
        r.last = last;
        r.typed = typed;
        r.typed_word = word;
        r.typed_ok = ok;
        rows.push_back(r);
    endtask

    task automatic send_packet();
        int unsigned n;
        int unsigned tl;
        int unsigned flavor;
        int unsigned bad;
        logic [7:0]  b;
        n = ($urandom_range(0, 9) == 0) ? $urandom_range(7, 20) : $urandom_range(1, 6);
        for (int i = 0; i < n; i++) begin
            send_item(8'($urandom_range(0, 255)), i == n - 1, 1'b0, '0, 1'b0);
        end
        if (in_trl) begin
            tl = eff_len(len_r);
            flavor = $urandom_range(0, 9);
            bad = $urandom_range(0, tl - 1);
            for (int k = 0; k < tl; k++) begin
                b = inv_byte(k);
                if (flavor == 0) begin
                    b = 8'($urandom_range(0, 255));
                end else if (flavor < 3 && k == bad) begin
                    b = b ^ (8'd1 << $urandom_range(0, 7));
                end
                // end flag on trailer bytes is ignored by the block
                send_item(b, 1'($urandom_range(0, 1)), 1'b0, '0, 1'b0);
            end
        end
    endtask

    // Result side: random stall bursts, none near the end
    always @(negedge aclk) begin
        if (stall_left > 0) begin
            m_tready = 1'b0;
            stall_left--;
        end else if (aresetn && !calm && $urandom_range(0, 4) == 0) begin
            m_tready = 1'b0;
            stall_left = $urandom_range(0, 2);
        end else begin
            m_tready = aresetn;
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            results_seen++;
            if (crc_expect_q.size() == 0) begin
                $error("unexpected result: crc_byte %0h crc_ok %0b last %0b",
                       m_tdata, m_tuser, m_tlast);
                err_count++;
            end else begin
                head = crc_expect_q.pop_front();
                if (m_tdata !== head.crc_byte) begin
                    $error("crc_byte: expected %0h, got %0h", head.crc_byte, m_tdata);
                    err_count++;
                end
                if (m_tuser !== head.ok) begin
                    $error("crc_ok: expected %0b, got %0b", head.ok, m_tuser);
                    err_count++;
                end
                if (m_tlast !== head.last) begin
                    $error("last_result: expected %0b, got %0b", head.last, m_tlast);
                    err_count++;
                end
            end
        end
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready)
                || (cfg_valid && cfg_ready)) begin
            idle_cycles = 0;
        end else begin
            idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("CHECK FAILED");
                $finish;
            end
        end
    end

    initial begin
        // Default CRC-32 over "123456789"
        for (int i = 0; i < 9; i++) begin
            add_row(ROW_ITEM, rcrc_pkg::CFG_POLYNOMIAL, 32'h31 + i, i == 8, i == 8,
                    32'hCBF43926, 1'b0);
        end
        // Zero polynomial and start value: every byte of the inverted CRC is 0xFF
        add_row(ROW_WRITE, rcrc_pkg::CFG_POLYNOMIAL, 32'h0, 1'b0, 1'b0, '0, 1'b0);
        add_row(ROW_WRITE, rcrc_pkg::CFG_INITIAL_VALUE, 32'h0, 1'b0, 1'b0, '0, 1'b0);
        add_row(ROW_WRITE, rcrc_pkg::CFG_CRC_LENGTH, 32'd0, 1'b0, 1'b0, '0, 1'b0);
        add_row(ROW_ITEM, rcrc_pkg::CFG_POLYNOMIAL, 32'hFF, 1'b1, 1'b1, 32'hFFFFFFFF, 1'b0);
        add_row(ROW_WRITE, rcrc_pkg::CFG_CRC_LENGTH, 32'd7, 1'b0, 1'b0, '0, 1'b0);
        add_row(ROW_ITEM, rcrc_pkg::CFG_POLYNOMIAL, 32'h00, 1'b1, 1'b1, 32'hFFFFFFFF, 1'b0);
        add_row(ROW_WRITE, rcrc_pkg::CFG_CRC_LENGTH, 32'd3, 1'b0, 1'b0, '0, 1'b0);
        add_row(ROW_ITEM, rcrc_pkg::CFG_POLYNOMIAL, 32'hA5, 1'b1, 1'b1, 32'hFFFFFFFF, 1'b0);
        // Check mode, two-byte trailer: one pass, one fail
        add_row(ROW_WRITE, rcrc_pkg::CFG_CHECK_MODE, 32'd1, 1'b0, 1'b0, '0, 1'b0);
        add_row(ROW_WRITE, rcrc_pkg::CFG_CRC_LENGTH, 32'd2, 1'b0, 1'b0, '0, 1'b0);
        add_row(ROW_ITEM, rcrc_pkg::CFG_POLYNOMIAL, 32'h12, 1'b1, 1'b0, '0, 1'b0);
        add_row(ROW_ITEM, rcrc_pkg::CFG_POLYNOMIAL, 32'hFF, 1'b0, 1'b0, '0, 1'b0);
        add_row(ROW_ITEM, rcrc_pkg::CFG_POLYNOMIAL, 32'hFF, 1'b0, 1'b1, 32'h0, 1'b1);
        add_row(ROW_ITEM, rcrc_pkg::CFG_POLYNOMIAL, 32'h00, 1'b1, 1'b0, '0, 1'b0);
        add_row(ROW_ITEM, rcrc_pkg::CFG_POLYNOMIAL, 32'hFF, 1'b0, 1'b0, '0, 1'b0);
        add_row(ROW_ITEM, rcrc_pkg::CFG_POLYNOMIAL, 32'h00, 1'b0, 1'b1, 32'h0, 1'b0);
        // Shorten the length and leave check mode in the middle of a trailer
        add_row(ROW_WRITE, rcrc_pkg::CFG_POLYNOMIAL, 32'hFFFFFFFF, 1'b0, 1'b0, '0, 1'b0);
        add_row(ROW_WRITE, rcrc_pkg::CFG_INITIAL_VALUE, 32'hFFFFFFFF, 1'b0, 1'b0, '0, 1'b0);
        add_row(ROW_WRITE, rcrc_pkg::CFG_CRC_LENGTH, 32'd4, 1'b0, 1'b0, '0, 1'b0);
        add_row(ROW_ITEM, rcrc_pkg::CFG_POLYNOMIAL, 32'h3C, 1'b1, 1'b0, '0, 1'b0);
        add_row(ROW_ITEM, rcrc_pkg::CFG_POLYNOMIAL, 32'h5A, 1'b0, 1'b0, '0, 1'b0);
        add_row(ROW_ITEM, rcrc_pkg::CFG_POLYNOMIAL, 32'hC3, 1'b0, 1'b0, '0, 1'b0);
        add_row(ROW_WRITE, rcrc_pkg::CFG_CRC_LENGTH, 32'd2, 1'b0, 1'b0, '0, 1'b0);
        add_row(ROW_WRITE, rcrc_pkg::CFG_CHECK_MODE, 32'd0, 1'b0, 1'b0, '0, 1'b0);
        add_row(ROW_ITEM, rcrc_pkg::CFG_POLYNOMIAL, 32'h81, 1'b1, 1'b0, '0, 1'b0);
        // Reload the start value in the middle of a packet
        add_row(ROW_ITEM, rcrc_pkg::CFG_POLYNOMIAL, 32'h55, 1'b0, 1'b0, '0, 1'b0);
        add_row(ROW_WRITE, rcrc_pkg::CFG_INITIAL_VALUE, 32'h12345678, 1'b0, 1'b0, '0, 1'b0);
        add_row(ROW_ITEM, rcrc_pkg::CFG_POLYNOMIAL, 32'hAA, 1'b1, 1'b0, '0, 1'b0);

        repeat (10) @(negedge aclk);
        aresetn = 1'b1;

        foreach (rows[i]) begin
            if (rows[i].kind == ROW_WRITE) begin
                wait_idle();
                write_reg(rows[i].reg_idx, rows[i].value);
            end else begin
                send_item(rows[i].value[7:0], rows[i].last, rows[i].typed,
                          rows[i].typed_word, rows[i].typed_ok);
            end
        end

        while (items_sent < ITEM_TARGET) begin
            wait_idle();
            case ($urandom_range(0, 4))
                0: write_reg(rcrc_pkg::CFG_POLYNOMIAL, 32'h0);
                1: write_reg(rcrc_pkg::CFG_POLYNOMIAL, 32'hFFFFFFFF);
                2: write_reg(rcrc_pkg::CFG_POLYNOMIAL, rcrc_pkg::POLY_RESET);
                3: write_reg(rcrc_pkg::CFG_POLYNOMIAL, 32'h0000A001);
                default: write_reg(rcrc_pkg::CFG_POLYNOMIAL, $urandom);
            endcase
            write_reg(rcrc_pkg::CFG_CRC_LENGTH, $urandom_range(0, 7));
            write_reg(rcrc_pkg::CFG_CHECK_MODE, $urandom_range(0, 1));
            case ($urandom_range(0, 3))
                0: write_reg(rcrc_pkg::CFG_INITIAL_VALUE, 32'h0);
                1: write_reg(rcrc_pkg::CFG_INITIAL_VALUE, 32'hFFFFFFFF);
                default: write_reg(rcrc_pkg::CFG_INITIAL_VALUE, $urandom);
            endcase
            repeat ($urandom_range(2, 5)) send_packet();
        end

        wait_idle();
        repeat (10) @(negedge aclk);

        $display("Sent %0d bytes and %0d register writes; checked %0d CRC results.",
                 items_sent, writes_done, results_seen);
        $display("Covered generate and check modes, clamped lengths, mid-packet writes.");
        if (err_count == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
